// ===== design/card_id_match_table_unit_macros.svh =====
// Assertion shorthands used by card_id_match_table_unit.
`ifndef CARD_ID_MATCH_TABLE_UNIT_MACROS_SVH
`define CARD_ID_MATCH_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CIMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CIMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cimt_pkg.sv =====
package cimt_pkg;

  localparam int TABLE_SLOTS = 32;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = SLOT_W + 1;
  localparam int USER_W      = 8;
  localparam int ID_W        = 32;
  localparam int OP_W        = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP     = 3'd0,
    OP_SAVE       = 3'd1,
    OP_DELETE_ONE = 3'd2,
    OP_DELETE_ALL = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

endpackage

// ===== design/cimt_ram.sv =====
module cimt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;
  logic [ADDR_W-1:0] raddr_chk;

  assign raddr_chk = raddr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr_chk];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/card_id_match_table_unit.sv =====
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | in_operation, in_card_id, in_user_number
// out_    | output    | out_valid/out_stall | out_found_user, out_free_user,
//         |           |                   | out_is_registered, out_bad_number
// An item's result word comes from the single scan over the identifier RAM, one slot
// read per cycle.
// The next word is taken in the cycle after the result is loaded.
// Reset clears all valid marks at once; identifiers are not cleared.
// A stalled result holds the block in its final state until it can be loaded.
`include "card_id_match_table_unit_macros.svh"

module card_id_match_table_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cimt_pkg::OP_W-1:0]    in_operation,
  input  logic [cimt_pkg::ID_W-1:0]    in_card_id,
  input  logic [cimt_pkg::USER_W-1:0]  in_user_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cimt_pkg::USER_W-1:0]  out_found_user,
  output logic [cimt_pkg::USER_W-1:0]  out_free_user,
  output logic                         out_is_registered,
  output logic                         out_bad_number
);

  import cimt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       iss_r, iss_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]      cmp_slot_r, cmp_slot_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic                   lookup_r, lookup_nxt;
  logic                   reg_r, reg_nxt;
  logic                   bad_r, bad_nxt;
  logic [USER_W-1:0]      found_r, found_nxt;
  logic [USER_W-1:0]      free_r, free_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [USER_W-1:0]      out_found_r, out_found_nxt;
  logic [USER_W-1:0]      out_free_r, out_free_nxt;
  logic                   out_reg_r, out_reg_nxt;
  logic                   out_bad_r, out_bad_nxt;

  logic                   in_fire;
  logic                   good;
  logic [USER_W-1:0]      num_m1;
  logic [SLOT_W-1:0]      in_slot;
  logic                   issuing;
  logic                   load_out;
  logic                   ram_we;
  logic [ID_W-1:0]        ram_rdata;
  logic [USER_W-1:0]      cmp_user;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  assign good    = (in_user_number != '0) && (in_user_number <= USER_W'(TABLE_SLOTS));
  assign num_m1  = in_user_number - USER_W'(1);
  assign in_slot = num_m1[SLOT_W-1:0];

  assign issuing  = (iss_r < CNT_W'(TABLE_SLOTS));
  assign load_out = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  assign ram_we   = in_fire && (in_operation == OP_SAVE) && good;
  assign cmp_user = USER_W'(cmp_slot_r) + USER_W'(1);

  cimt_ram #(
    .WIDTH(ID_W),
    .DEPTH(TABLE_SLOTS)
  ) u_id_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_slot),
    .wdata(in_card_id),
    .raddr(iss_r[SLOT_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    iss_nxt      = iss_r;
    cmp_vld_nxt  = 1'b0;
    cmp_slot_nxt = cmp_slot_r;
    id_nxt       = id_r;
    lookup_nxt   = lookup_r;
    reg_nxt      = reg_r;
    bad_nxt      = bad_r;
    found_nxt    = found_r;
    free_nxt     = free_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          id_nxt     = in_card_id;
          lookup_nxt = (in_operation == OP_LOOKUP);
          reg_nxt    = 1'b0;
          bad_nxt    = 1'b0;
          found_nxt  = '0;
          free_nxt   = '0;
          iss_nxt    = '0;
          unique case (in_operation)
            OP_SAVE: begin
              if (good) begin
                valid_nxt[in_slot] = 1'b1;
              end else begin
                bad_nxt = 1'b1;
              end
            end
            OP_DELETE_ONE: begin
              if (good) begin
                valid_nxt[in_slot] = 1'b0;
              end else begin
                bad_nxt = 1'b1;
              end
            end
            OP_DELETE_ALL: begin
              valid_nxt = '0;
            end
            OP_QUERY: begin
              if (good) begin
                reg_nxt = valid_r[in_slot];
              end else begin
                bad_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Read address runs one slot ahead of the compare.
        if (issuing) begin
          iss_nxt      = iss_r + CNT_W'(1);
          cmp_vld_nxt  = 1'b1;
          cmp_slot_nxt = iss_r[SLOT_W-1:0];
        end else begin
          state_nxt = ST_FINISH;
        end
        if (cmp_vld_r) begin
          if (!valid_r[cmp_slot_r] && (free_r == '0)) begin
            free_nxt = cmp_user;
          end
          if (lookup_r && valid_r[cmp_slot_r] && (ram_rdata == id_r) && (found_r == '0)) begin
            found_nxt = cmp_user;
          end
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_free_nxt  = out_free_r;
    out_reg_nxt   = out_reg_r;
    out_bad_nxt   = out_bad_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found_r;
      out_free_nxt  = free_r;
      out_reg_nxt   = reg_r;
      out_bad_nxt   = bad_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r       <= iss_nxt;
    cmp_slot_r  <= cmp_slot_nxt;
    id_r        <= id_nxt;
    lookup_r    <= lookup_nxt;
    reg_r       <= reg_nxt;
    bad_r       <= bad_nxt;
    found_r     <= found_nxt;
    free_r      <= free_nxt;
    out_found_r <= out_found_nxt;
    out_free_r  <= out_free_nxt;
    out_reg_r   <= out_reg_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found_user    = out_found_r;
  assign out_free_user     = out_free_r;
  assign out_is_registered = out_reg_r;
  assign out_bad_number    = out_bad_r;

  `CIMT_ASSERT_NEXT(a_delete_all_clears, in_fire && (in_operation == OP_DELETE_ALL), valid_r == '0, "delete all left a valid mark")
  `CIMT_ASSERT_NOW(a_found_only_on_lookup, out_valid_r && (out_found_r != '0), !out_reg_r && !out_bad_r, "match reported with query or bad-number flags")
  `CIMT_ASSERT_NOW(a_users_in_range, out_valid_r, (out_found_r <= USER_W'(TABLE_SLOTS)) && (out_free_r <= USER_W'(TABLE_SLOTS)), "reported user number beyond the table")
  `CIMT_ASSERT_NEXT(a_finish_loads_word, load_out, out_valid_r && (state_r == ST_IDLE), "finished scan did not present a word")
  `CIMT_ASSERT_NOW(a_scan_bounded, state_r == ST_SCAN, iss_r <= CNT_W'(TABLE_SLOTS), "scan counter ran past the table")

endmodule

// ===== tb/card_id_match_table_unit_tb.sv =====
`timescale 1ns / 1ps

module card_id_match_table_unit_tb;
  import cimt_pkg::*;

  localparam int ITEM_TARGET  = 1750;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_WORD = 400;
  localparam int WATCHDOG_MAX = 4000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [USER_W-1:0] found_user;
    logic [USER_W-1:0] free_user;
    logic              is_registered;
    logic              bad_number;
  } table_reply_t;

  class card_table_scoreboard;
    bit                 slot_used[TABLE_SLOTS];
    logic [ID_W-1:0]    slot_id[TABLE_SLOTS];
    table_reply_t       replies_due[$];
    int                 mismatches;

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [USER_W-1:0] num);
      table_reply_t r;
      bit           good;
      int           slot;
      int           i;
      r = '0;
      good = (num >= 1) && (num <= TABLE_SLOTS);
      slot = good ? int'(num) - 1 : 0;
      case (op)
        OP_LOOKUP: begin
          // Scan downwards so that the lowest matching slot wins.
          for (i = TABLE_SLOTS - 1; i >= 0; i--)
            if (slot_used[i] && slot_id[i] == id) r.found_user = USER_W'(i + 1);
        end
        OP_SAVE: begin
          if (good) begin
            slot_id[slot] = id;
            slot_used[slot] = 1'b1;
          end else begin
            r.bad_number = 1'b1;
          end
        end
        OP_DELETE_ONE: begin
          if (good) slot_used[slot] = 1'b0;
          else r.bad_number = 1'b1;
        end
        OP_DELETE_ALL: begin
          for (i = 0; i < TABLE_SLOTS; i++) slot_used[i] = 1'b0;
        end
        OP_QUERY: begin
          if (good) r.is_registered = slot_used[slot];
          else r.bad_number = 1'b1;
        end
        default: ;
      endcase
      for (i = TABLE_SLOTS - 1; i >= 0; i--)
        if (!slot_used[i]) r.free_user = USER_W'(i + 1);
      replies_due.push_back(r);
    endfunction

    function void report(string field, int expected, int actual);
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, expected, actual);
    endfunction

    function void check_reply(table_reply_t got);
      table_reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, expected none, got %h",
                 $time, got);
        return;
      end
      want = replies_due.pop_front();
      if (got.found_user !== want.found_user)
        report("found_user", want.found_user, got.found_user);
      if (got.free_user !== want.free_user)
        report("free_user", want.free_user, got.free_user);
      if (got.is_registered !== want.is_registered)
        report("is_registered", want.is_registered, got.is_registered);
      if (got.bad_number !== want.bad_number)
        report("bad_number", want.bad_number, got.bad_number);
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation;
  logic [ID_W-1:0]   in_card_id;
  logic [USER_W-1:0] in_user_number;
  logic              out_valid;
  logic              out_stall;
  logic [USER_W-1:0] out_found_user;
  logic [USER_W-1:0] out_free_user;
  logic              out_is_registered;
  logic              out_bad_number;

  card_table_scoreboard sb;
  int                   words_sent;
  bit                   calm;
  logic [ID_W-1:0]      id_pool[16];

  card_id_match_table_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_card_id       (in_card_id),
    .in_user_number   (in_user_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found_user   (out_found_user),
    .out_free_user    (out_free_user),
    .out_is_registered(out_is_registered),
    .out_bad_number   (out_bad_number)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one request word and holds it until the block takes it.
  task automatic send_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic [USER_W-1:0] num);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_card_id     <= id;
    in_user_number <= num;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, id, num);
    if (op == OP_SAVE) id_pool[$urandom_range(15)] = id;
    words_sent++;
    calm = (words_sent >= 700) && (words_sent < 1000);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(3) == 0) return id_pool[$urandom_range(15)];
    return $urandom;
  endfunction

  function automatic logic [USER_W-1:0] good_number();
    return USER_W'($urandom_range(TABLE_SLOTS, 1));
  endfunction

  function automatic logic [USER_W-1:0] bad_number();
    if ($urandom_range(1) == 0) return '0;
    return USER_W'($urandom_range(255, TABLE_SLOTS + 1));
  endfunction

  task automatic random_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30)
      send_word(OP_SAVE, pick_id(),
                ($urandom_range(9) == 0) ? bad_number() : good_number());
    else if (roll < 55)
      send_word(OP_LOOKUP, ($urandom_range(9) < 7) ? id_pool[$urandom_range(15)] : $urandom,
                USER_W'($urandom_range(255)));
    else if (roll < 70)
      send_word(OP_QUERY, $urandom,
                ($urandom_range(7) == 0) ? bad_number() : good_number());
    else if (roll < 82)
      send_word(OP_DELETE_ONE, $urandom,
                ($urandom_range(7) == 0) ? bad_number() : good_number());
    else if (roll < 85)
      send_word(OP_DELETE_ALL, $urandom, USER_W'($urandom_range(255)));
    else if (roll < 90)
      send_word(OP_W'($urandom_range(7, 5)), $urandom, USER_W'($urandom_range(255)));
    else
      send_word(OP_W'($urandom_range(7)), $urandom, USER_W'($urandom_range(255)));
  endtask

  // Saves every slot in a shuffled order, works on the full table, then may free some or all of it.
  task automatic fill_table();
    int order[TABLE_SLOTS];
    int j;
    int k;
    int tmp;
    for (k = 0; k < TABLE_SLOTS; k++) order[k] = k + 1;
    for (k = TABLE_SLOTS - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < TABLE_SLOTS; k++) begin
      send_word(OP_SAVE, pick_id(), USER_W'(order[k]));
      if ($urandom_range(3) == 0)
        send_word(OP_LOOKUP, id_pool[$urandom_range(15)], USER_W'($urandom_range(255)));
    end
    repeat ($urandom_range(5, 2)) begin
      send_word(OP_QUERY, $urandom, USER_W'($urandom_range(TABLE_SLOTS + 1, 0)));
      send_word(OP_LOOKUP, ($urandom_range(1) == 0) ? id_pool[$urandom_range(15)] : $urandom,
                USER_W'($urandom_range(255)));
    end
    repeat ($urandom_range(3)) begin
      send_word(OP_DELETE_ONE, $urandom, good_number());
      send_word(OP_QUERY, $urandom, good_number());
    end
    if ($urandom_range(1) == 0)
      send_word(OP_DELETE_ALL, $urandom, USER_W'($urandom_range(255)));
  endtask

  // Result side: random stalls, one long hold-off, and the check of each word taken.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall)
        sb.check_reply({out_found_user, out_free_user, out_is_registered, out_bad_number});
      if (hold_left == 0 && !hold_done && words_sent >= HOLD_AT_WORD) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 36);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_MAX) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("card_id_match_table_unit_tb failed");
    $finish;
  end

  initial begin
    int k;
    sb = new();
    words_sent = 0;
    calm = 1'b0;
    for (k = 0; k < 16; k++) id_pool[k] = $urandom;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_operation   <= OP_LOOKUP;
    in_card_id     <= '0;
    in_user_number <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, bad numbers, slot extremes, duplicates, overwrite, unknown codes.
    send_word(OP_QUERY, 32'h0, 8'd1);
    send_word(OP_LOOKUP, 32'h0, 8'd0);
    send_word(OP_SAVE, 32'h1234_5678, 8'd0);
    send_word(OP_SAVE, 32'h1234_5678, USER_W'(TABLE_SLOTS + 1));
    send_word(OP_SAVE, 32'h1234_5678, 8'd255);
    send_word(OP_DELETE_ONE, 32'h0, 8'd0);
    send_word(OP_QUERY, 32'hFFFF_FFFF, USER_W'(TABLE_SLOTS + 1));
    send_word(OP_QUERY, 32'hFFFF_FFFF, 8'd0);
    send_word(OP_SAVE, 32'hFFFF_FFFF, 8'd1);
    send_word(OP_SAVE, 32'h0000_0000, USER_W'(TABLE_SLOTS));
    send_word(OP_SAVE, 32'hFFFF_FFFF, 8'd2);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 8'd255);
    send_word(OP_LOOKUP, 32'h0000_0000, 8'd0);
    send_word(OP_LOOKUP, 32'h1234_5678, 8'd1);
    send_word(OP_SAVE, 32'hA5A5_A5A5, 8'd1);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 8'd0);
    send_word(OP_QUERY, 32'h0, USER_W'(TABLE_SLOTS));
    send_word(OP_QUERY, 32'h0, 8'd3);
    send_word(OP_DELETE_ONE, 32'h0, 8'd2);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 8'd0);
    send_word(OP_W'(5), 32'h5A5A_5A5A, 8'd1);
    send_word(OP_W'(6), 32'hFFFF_FFFF, 8'd255);
    send_word(OP_W'(7), 32'h0, 8'd0);
    send_word(OP_DELETE_ALL, 32'hFFFF_FFFF, 8'd255);
    send_word(OP_QUERY, 32'h0, 8'd1);

    while (words_sent < ITEM_TARGET) begin
      if ($urandom_range(9) < 3) fill_table();
      else repeat (20) random_word();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("card_id_match_table_unit_tb passed");
    else
      $display("card_id_match_table_unit_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/cimt_pkg.sv
design/cimt_ram.sv
design/card_id_match_table_unit.sv
tb/card_id_match_table_unit_tb.sv
